### rtl/core/two_lane_message_queue_core_defines.svh
// Assertion helpers for the checker file
`ifndef TWO_LANE_MESSAGE_QUEUE_CORE_DEFINES_SVH
`define TWO_LANE_MESSAGE_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TLMQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlmq assertion failed");

// Next-cycle implication, disabled during reset
`define TLMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlmq assertion failed");

`endif

### rtl/core/tlmq_pkg.sv
package tlmq_pkg;

    localparam int SLOTS       = 16;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int MAX_CANCELS = 4;
    localparam int PC_IDX_W    = $clog2(MAX_CANCELS);
    localparam int PC_CNT_W    = $clog2(MAX_CANCELS + 1);
    localparam int WIRE_MEMORY = 8;
    localparam int WIRE_IDX_W  = $clog2(WIRE_MEMORY);
    localparam int WIRE_CNT_W  = $clog2(WIRE_MEMORY + 1);

    localparam logic [3:0] MODE_START    = 4'd0;
    localparam logic [3:0] MODE_AUDIO    = 4'd1;
    localparam logic [3:0] MODE_END      = 4'd2;
    localparam logic [3:0] MODE_CANCEL   = 4'd3;
    localparam logic [3:0] MODE_CREDIT   = 4'd4;
    localparam logic [3:0] MODE_PING     = 4'd5;
    localparam logic [3:0] MODE_BEGIN    = 4'd6;
    localparam logic [3:0] MODE_COMPLETE = 4'd7;
    localparam logic [3:0] MODE_FAIL     = 4'd8;

    localparam logic [2:0] KIND_START  = 3'd0;
    localparam logic [2:0] KIND_AUDIO  = 3'd1;
    localparam logic [2:0] KIND_END    = 3'd2;
    localparam logic [2:0] KIND_CANCEL = 3'd3;
    localparam logic [2:0] KIND_CREDIT = 3'd4;
    localparam logic [2:0] KIND_PING   = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic CFG_RESERVED  = 1'b0;
    localparam logic CFG_MAX_AUDIO = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic        send_valid;
        logic [3:0]  send_slot;
        logic [2:0]  send_kind;
        logic        send_lane;
        logic [31:0] send_turn;
        logic [31:0] send_value;
        logic [4:0]  high_water;
    } t_result;

endpackage

### rtl/core/tlmq_in_if.sv
interface tlmq_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  mode;
    logic [31:0] turn;
    logic [31:0] amount;

    modport source (output valid, output mode, output turn, output amount, input ready);
    modport sink (input valid, input mode, input turn, input amount, output ready);
endinterface

### rtl/core/tlmq_out_if.sv
interface tlmq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        send_valid;
    logic [3:0]  send_slot;
    logic [2:0]  send_kind;
    logic        send_lane;
    logic [31:0] send_turn;
    logic [31:0] send_value;
    logic [4:0]  high_water;

    modport source (output valid, output status, output send_valid, output send_slot,
                    output send_kind, output send_lane, output send_turn,
                    output send_value, output high_water, input ready);
    modport sink (input valid, input status, input send_valid, input send_slot,
                  input send_kind, input send_lane, input send_turn,
                  input send_value, input high_water, output ready);
endinterface

### rtl/core/tlmq_engine.sv
module tlmq_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [3:0]        i_mode,
    input  logic [31:0]       i_turn,
    input  logic [31:0]       i_amount,
    input  logic [4:0]        i_reserved,
    input  logic [12:0]       i_max_audio,
    input  logic              i_out_free,
    output logic              o_res_valid,
    output tlmq_pkg::t_result o_res
);
    import tlmq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CSCAN, S_CRSCAN, S_TAKE, S_PURGE, S_WSCAN, S_NEXTC, S_PICK, S_CPL, S_DONE
    } t_state;

    t_state r_state;

    logic [SLOT_W-1:0]   r_free_stack [SLOTS];
    logic [SLOTS-1:0]    r_fs_vld;
    logic [CNT_W-1:0]    r_free_cnt;
    logic [SLOT_W-1:0]   r_ord_ring [SLOTS];
    logic [SLOT_W-1:0]   r_ord_head;
    logic [CNT_W-1:0]    r_ord_cnt;
    logic [SLOT_W-1:0]   r_pri_ring [SLOTS];
    logic [SLOT_W-1:0]   r_pri_head;
    logic [CNT_W-1:0]    r_pri_cnt;
    logic                r_infl_valid;
    logic [SLOT_W-1:0]   r_infl_slot;
    logic                r_infl_pri;
    logic [31:0]         r_open_turn;
    logic [31:0]         r_pc [MAX_CANCELS];
    logic [PC_CNT_W-1:0] r_pc_cnt;
    logic [PC_IDX_W-1:0] r_cidx;
    logic [31:0]         r_wire [WIRE_MEMORY];
    logic [WIRE_CNT_W-1:0] r_wire_cnt;
    logic [WIRE_IDX_W-1:0] r_wire_head;
    logic [2:0]          r_slot_kind [SLOTS];
    logic [31:0]         r_slot_turn [SLOTS];
    logic [31:0]         r_slot_value [SLOTS];
    logic [CNT_W-1:0]    r_peak;

    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_kept;
    logic [31:0]         r_turn;
    logic [31:0]         r_amount;
    logic [31:0]         r_cur_turn;
    logic                r_wfor_cancel;
    logic [1:0]          r_status;
    logic                r_sv;
    logic [2:0]          r_tk_kind;
    logic [31:0]         r_tk_turn;
    logic [31:0]         r_tk_val;
    logic                r_tk_pri;
    logic                r_tk_res;
    logic                r_tk_cancel;

    logic [SLOT_W-1:0]   ord_addr, pri_addr, sl_addr, fs_addr, ord_rd, pri_rd, fs_rd;
    logic [2:0]          sl_kind;
    logic [31:0]         sl_turn, sl_value, pc_rd, wire_rd;
    logic [PC_IDX_W-1:0] pc_addr;
    logic [32:0]         cr_sum;
    logic [CNT_W-1:0]    tk_floor, used_next;
    logic                take_ok;

    assign ord_addr = r_ord_head + r_idx[SLOT_W-1:0];
    assign pri_addr = r_pri_head + r_idx[SLOT_W-1:0];
    assign ord_rd   = r_ord_ring[ord_addr];
    assign pri_rd   = r_pri_ring[pri_addr];

    always_comb begin
        unique case (r_state)
            S_PURGE:  sl_addr = ord_rd;
            S_CRSCAN: sl_addr = pri_rd;
            default:  sl_addr = r_infl_slot;
        endcase
    end

    assign sl_kind  = r_slot_kind[sl_addr];
    assign sl_turn  = r_slot_turn[sl_addr];
    assign sl_value = r_slot_value[sl_addr];

    assign fs_addr = SLOT_W'(r_free_cnt - CNT_W'(1));
    assign fs_rd   = r_fs_vld[fs_addr] ? r_free_stack[fs_addr]
                                       : SLOT_W'(SLOTS - 1) - fs_addr;

    assign pc_addr = (r_state == S_CSCAN) ? r_idx[PC_IDX_W-1:0] : r_cidx;
    assign pc_rd   = r_pc[pc_addr];
    assign wire_rd = r_wire[r_idx[WIRE_IDX_W-1:0]];

    assign cr_sum    = {1'b0, sl_value} + {1'b0, r_amount};
    assign tk_floor  = r_tk_res ? '0 : i_reserved;
    assign take_ok   = (r_free_cnt != '0) && (r_free_cnt > tk_floor);
    assign used_next = CNT_W'(SLOTS) - (r_free_cnt - CNT_W'(1));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE) && i_out_free;

    always_comb begin
        o_res            = '0;
        o_res.status     = r_status;
        o_res.send_valid = r_sv;
        o_res.high_water = r_peak;
        if (r_sv) begin
            o_res.send_slot  = r_infl_slot;
            o_res.send_kind  = sl_kind;
            o_res.send_lane  = r_infl_pri;
            o_res.send_turn  = sl_turn;
            o_res.send_value = sl_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fs_vld     <= '0;
            r_free_cnt   <= CNT_W'(SLOTS);
            r_ord_head   <= '0;
            r_ord_cnt    <= '0;
            r_pri_head   <= '0;
            r_pri_cnt    <= '0;
            r_infl_valid <= 1'b0;
            r_infl_slot  <= '0;
            r_infl_pri   <= 1'b0;
            r_open_turn  <= '0;
            r_pc_cnt     <= '0;
            r_cidx       <= '0;
            r_wire_cnt   <= '0;
            r_wire_head  <= '0;
            r_peak       <= '0;
            r_idx        <= '0;
            r_kept       <= '0;
            r_status     <= ST_OK;
            r_sv         <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_turn      <= i_turn;
                        r_amount    <= i_amount;
                        r_status    <= ST_OK;
                        r_sv        <= 1'b0;
                        r_idx       <= '0;
                        r_kept      <= '0;
                        r_cidx      <= '0;
                        r_tk_turn   <= i_turn;
                        r_tk_val    <= '0;
                        r_tk_pri    <= 1'b0;
                        r_tk_res    <= 1'b1;
                        r_tk_cancel <= 1'b0;
                        r_state     <= S_DONE;
                        unique case (i_mode)
                            MODE_START: begin
                                r_tk_kind <= KIND_START;
                                if (i_turn == '0 || r_open_turn != '0) r_status <= ST_INVALID;
                                else r_state <= S_TAKE;
                            end
                            MODE_AUDIO: begin
                                r_tk_kind <= KIND_AUDIO;
                                r_tk_val  <= i_amount;
                                r_tk_res  <= 1'b0;
                                if (i_turn == '0 || i_turn != r_open_turn || i_amount == '0
                                    || i_amount > {19'd0, i_max_audio}) begin
                                    r_status <= ST_INVALID;
                                end else begin
                                    r_state <= S_TAKE;
                                end
                            end
                            MODE_END: begin
                                r_tk_kind <= KIND_END;
                                if (i_turn == '0 || i_turn != r_open_turn) r_status <= ST_INVALID;
                                else r_state <= S_TAKE;
                            end
                            MODE_CANCEL: begin
                                if (i_turn == '0) begin
                                    r_status <= ST_INVALID;
                                end else begin
                                    if (r_open_turn == i_turn) r_open_turn <= '0;
                                    r_state <= S_CSCAN;
                                end
                            end
                            MODE_CREDIT: begin
                                r_tk_kind <= KIND_CREDIT;
                                r_tk_turn <= '0;
                                r_tk_val  <= i_amount;
                                r_tk_pri  <= 1'b1;
                                if (i_amount != '0) r_state <= S_CRSCAN;
                            end
                            MODE_PING: begin
                                r_tk_kind <= KIND_PING;
                                r_tk_turn <= '0;
                                r_tk_pri  <= 1'b1;
                                r_tk_res  <= 1'b0;
                                r_state   <= S_TAKE;
                            end
                            MODE_BEGIN: begin
                                if (r_infl_valid) r_sv <= 1'b1;
                                else if (r_pc_cnt != '0) r_state <= S_PURGE;
                                else r_state <= S_PICK;
                            end
                            MODE_COMPLETE: begin
                                if (r_infl_valid) begin
                                    if (sl_kind == KIND_START) begin
                                        r_cur_turn    <= sl_turn;
                                        r_wfor_cancel <= 1'b0;
                                        r_state       <= S_WSCAN;
                                    end else begin
                                        r_state <= S_CPL;
                                    end
                                end
                            end
                            MODE_FAIL: begin
                                r_fs_vld     <= '0;
                                r_free_cnt   <= CNT_W'(SLOTS);
                                r_ord_head   <= '0;
                                r_ord_cnt    <= '0;
                                r_pri_head   <= '0;
                                r_pri_cnt    <= '0;
                                r_infl_valid <= 1'b0;
                                r_infl_slot  <= '0;
                                r_infl_pri   <= 1'b0;
                                r_open_turn  <= '0;
                                r_pc_cnt     <= '0;
                                r_wire_cnt   <= '0;
                                r_wire_head  <= '0;
                            end
                            default: r_status <= ST_INVALID;
                        endcase
                    end
                end

                S_CSCAN: begin
                    if (r_idx < CNT_W'(r_pc_cnt)) begin
                        if (pc_rd == r_turn) r_state <= S_DONE;
                        else r_idx <= r_idx + CNT_W'(1);
                    end else begin
                        if (r_pc_cnt < PC_CNT_W'(MAX_CANCELS)) begin
                            r_pc[r_pc_cnt[PC_IDX_W-1:0]] <= r_turn;
                            r_pc_cnt <= r_pc_cnt + PC_CNT_W'(1);
                        end else begin
                            // drop the oldest, append the new turn
                            for (int i = 1; i < MAX_CANCELS; i++) r_pc[i-1] <= r_pc[i];
                            r_pc[MAX_CANCELS-1] <= r_turn;
                        end
                        r_state <= S_DONE;
                    end
                end

                S_CRSCAN: begin
                    if (r_idx < r_pri_cnt) begin
                        if ((r_infl_valid && pri_rd == r_infl_slot) || sl_kind != KIND_CREDIT) begin
                            r_idx <= r_idx + CNT_W'(1);
                        end else if (cr_sum[32]) begin
                            r_state <= S_TAKE;
                        end else begin
                            r_slot_value[pri_rd] <= cr_sum[31:0];
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_TAKE;
                    end
                end

                S_TAKE: begin
                    if (take_ok) begin
                        r_slot_kind[fs_rd]  <= r_tk_kind;
                        r_slot_turn[fs_rd]  <= r_tk_turn;
                        r_slot_value[fs_rd] <= r_tk_val;
                        if (r_tk_pri) begin
                            r_pri_ring[r_pri_head + r_pri_cnt[SLOT_W-1:0]] <= fs_rd;
                            if (r_pri_cnt < CNT_W'(SLOTS)) r_pri_cnt <= r_pri_cnt + CNT_W'(1);
                        end else begin
                            r_ord_ring[r_ord_head + r_ord_cnt[SLOT_W-1:0]] <= fs_rd;
                            if (r_ord_cnt < CNT_W'(SLOTS)) r_ord_cnt <= r_ord_cnt + CNT_W'(1);
                        end
                        r_free_cnt <= r_free_cnt - CNT_W'(1);
                        if (used_next > r_peak) r_peak <= used_next;
                        if (!r_tk_cancel && r_tk_kind == KIND_START) r_open_turn <= r_tk_turn;
                        if (!r_tk_cancel && r_tk_kind == KIND_END) r_open_turn <= '0;
                    end else if (!r_tk_cancel) begin
                        r_status <= ST_BUSY;
                    end
                    r_state <= r_tk_cancel ? S_NEXTC : S_DONE;
                end

                S_PURGE: begin
                    // compact in place behind the read position
                    if (r_idx < r_ord_cnt) begin
                        if (sl_turn == pc_rd) begin
                            if (r_free_cnt < CNT_W'(SLOTS)) begin
                                r_free_stack[r_free_cnt[SLOT_W-1:0]] <= ord_rd;
                                r_fs_vld[r_free_cnt[SLOT_W-1:0]]     <= 1'b1;
                                r_free_cnt <= r_free_cnt + CNT_W'(1);
                            end
                        end else begin
                            r_ord_ring[r_ord_head + r_kept[SLOT_W-1:0]] <= ord_rd;
                            r_kept <= r_kept + CNT_W'(1);
                        end
                        r_idx <= r_idx + CNT_W'(1);
                    end else begin
                        r_ord_cnt     <= r_kept;
                        r_cur_turn    <= pc_rd;
                        r_wfor_cancel <= 1'b1;
                        r_idx         <= '0;
                        r_state       <= S_WSCAN;
                    end
                end

                S_WSCAN: begin
                    if (r_idx < CNT_W'(r_wire_cnt) && wire_rd != r_cur_turn) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end else if (r_idx < CNT_W'(r_wire_cnt)) begin
                        if (r_wfor_cancel) begin
                            r_tk_kind   <= KIND_CANCEL;
                            r_tk_turn   <= r_cur_turn;
                            r_tk_val    <= '0;
                            r_tk_pri    <= 1'b1;
                            r_tk_res    <= 1'b1;
                            r_tk_cancel <= 1'b1;
                            r_state     <= S_TAKE;
                        end else begin
                            r_state <= S_CPL;
                        end
                    end else begin
                        if (r_wfor_cancel) begin
                            r_state <= S_NEXTC;
                        end else begin
                            r_wire[r_wire_head] <= r_cur_turn;
                            r_wire_head <= r_wire_head + WIRE_IDX_W'(1);
                            if (r_wire_cnt < WIRE_CNT_W'(WIRE_MEMORY))
                                r_wire_cnt <= r_wire_cnt + WIRE_CNT_W'(1);
                            r_state <= S_CPL;
                        end
                    end
                end

                S_NEXTC: begin
                    r_idx  <= '0;
                    r_kept <= '0;
                    if (PC_CNT_W'(r_cidx) + PC_CNT_W'(1) < r_pc_cnt) begin
                        r_cidx  <= r_cidx + PC_IDX_W'(1);
                        r_state <= S_PURGE;
                    end else begin
                        r_state <= S_PICK;
                    end
                end

                S_PICK: begin
                    r_pc_cnt <= '0;
                    if (r_pri_cnt != '0) begin
                        r_infl_slot  <= pri_rd;
                        r_infl_pri   <= 1'b1;
                        r_infl_valid <= 1'b1;
                        r_sv         <= 1'b1;
                    end else if (r_ord_cnt != '0) begin
                        r_infl_slot  <= ord_rd;
                        r_infl_pri   <= 1'b0;
                        r_infl_valid <= 1'b1;
                        r_sv         <= 1'b1;
                    end
                    r_state <= S_DONE;
                end

                S_CPL: begin
                    if (r_infl_pri) begin
                        r_pri_head <= r_pri_head + SLOT_W'(1);
                        if (r_pri_cnt != '0) r_pri_cnt <= r_pri_cnt - CNT_W'(1);
                    end else begin
                        r_ord_head <= r_ord_head + SLOT_W'(1);
                        if (r_ord_cnt != '0) r_ord_cnt <= r_ord_cnt - CNT_W'(1);
                    end
                    if (r_free_cnt < CNT_W'(SLOTS)) begin
                        r_free_stack[r_free_cnt[SLOT_W-1:0]] <= r_infl_slot;
                        r_fs_vld[r_free_cnt[SLOT_W-1:0]]     <= 1'b1;
                        r_free_cnt <= r_free_cnt + CNT_W'(1);
                    end
                    r_infl_valid <= 1'b0;
                    r_infl_slot  <= '0;
                    r_state      <= S_DONE;
                end

                S_DONE: begin
                    if (i_out_free) r_state <= S_IDLE;
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/two_lane_message_queue_core.sv
// Outbound message scheduler with an ordered lane and a priority lane.
// i_in carries one request per transaction (mode, turn, amount); o_out returns
// exactly one result transaction per request: status, the item to transmit on
// begin-send, and the high-water mark of slots in use.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 reserved slot count, 1 largest audio sample count); write only when idle.
// One request at a time goes through a sequencer that walks the rings,
// the cancel list and the wire list one entry per cycle.
// Invalid requests, fail and cancel-free no-ops go straight to the result;
// pushes, ping and complete of a non-start item first take or free a slot;
// a cancel request first scans the cancel list, a credit the priority ring,
// complete of a start the wire list; begin-send, for each pending cancel,
// purges the ordered ring, scans the wire list and queues a cancel item
// when that turn is on the wire.
// i_in.ready is high only while the sequencer is idle, so a new request can be
// taken at the earliest in the cycle after the previous result leaves the sequencer.
// A finished result sits in an output register; the next request is accepted
// while it waits, and the sequencer holds its own result until o_out.ready.
// Reset (synchronous, active low) empties every queue and restores the
// registers to 2 reserved slots and 512 samples; no clearing pass is needed.
module two_lane_message_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlmq_in_if.sink     i_in,
    tlmq_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data
);
    import tlmq_pkg::*;

    logic [4:0]  r_reserved;
    logic [12:0] r_max_audio;
    logic        r_ovalid;
    t_result     r_out;
    logic        out_free;
    logic        res_valid;
    t_result     res;

    assign out_free = !r_ovalid || o_out.ready;

    tlmq_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_mode      (i_in.mode),
        .i_turn      (i_in.turn),
        .i_amount    (i_in.amount),
        .i_reserved  (r_reserved),
        .i_max_audio (r_max_audio),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved  <= 5'd2;
            r_max_audio <= 13'd512;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RESERVED:  r_reserved  <= i_cfg_data[4:0];
                    CFG_MAX_AUDIO: r_max_audio <= i_cfg_data;
                    default:       r_reserved  <= r_reserved;
                endcase
            end
            if (res_valid) begin
                r_ovalid <= 1'b1;
                r_out    <= res;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.status     = r_out.status;
    assign o_out.send_valid = r_out.send_valid;
    assign o_out.send_slot  = r_out.send_slot;
    assign o_out.send_kind  = r_out.send_kind;
    assign o_out.send_lane  = r_out.send_lane;
    assign o_out.send_turn  = r_out.send_turn;
    assign o_out.send_value = r_out.send_value;
    assign o_out.high_water = r_out.high_water;

endmodule

### rtl/core/tlmq_checker.sv
`include "two_lane_message_queue_core_defines.svh"

module tlmq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic        i_send_valid,
    input logic [3:0]  i_send_slot,
    input logic [2:0]  i_send_kind,
    input logic        i_send_lane,
    input logic [31:0] i_send_turn,
    input logic [31:0] i_send_value,
    input logic [4:0]  i_high_water
);
    // a result stays offered until taken
    `TLMQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // a taken request leaves the sequencer busy in the next cycle
    `TLMQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `TLMQ_ASSERT_IMPLY(a_status_code, i_clk, i_rst_n, i_out_valid, i_status != 2'd3)
    // send fields stay zero when nothing is sent
    `TLMQ_ASSERT_IMPLY(a_send_zero, i_clk, i_rst_n, i_out_valid && !i_send_valid,
        i_send_slot == 4'd0 && i_send_kind == 3'd0 && !i_send_lane && i_send_turn == 32'd0 && i_send_value == 32'd0)
    `TLMQ_ASSERT_IMPLY(a_peak_range, i_clk, i_rst_n, i_out_valid,
        i_high_water <= 5'd16 && (!i_send_valid || i_send_kind <= 3'd5))
endmodule

bind two_lane_message_queue_core tlmq_checker u_tlmq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_send_valid (o_out.send_valid),
    .i_send_slot  (o_out.send_slot),
    .i_send_kind  (o_out.send_kind),
    .i_send_lane  (o_out.send_lane),
    .i_send_turn  (o_out.send_turn),
    .i_send_value (o_out.send_value),
    .i_high_water (o_out.high_water)
);
